FILE: rtl/m3i_pkg.sv
// Shared types, widths and the cofactor index table of the 3x3 matrix inverse.
package m3i_pkg;

  localparam int unsigned M3I_FRAC_BITS = 16;
  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned PROD_W        = 2 * ELEM_W;
  localparam int unsigned COF_W         = PROD_W + 1;
  localparam int unsigned DET_W         = 98;
  localparam int unsigned DMAG_W        = DET_W - 1;
  localparam int unsigned QW            = 33;
  localparam int unsigned N_ELEM        = 9;
  localparam int unsigned N_ROW         = 3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    elem_t v0_x; elem_t v0_y; elem_t v0_z;
    elem_t v1_x; elem_t v1_y; elem_t v1_z;
    elem_t v2_x; elem_t v2_y; elem_t v2_z;
  } mat_in_t;

  typedef struct packed {
    elem_t inv0_x; elem_t inv0_y; elem_t inv0_z;
    elem_t inv1_x; elem_t inv1_y; elem_t inv1_z;
    elem_t inv2_x; elem_t inv2_y; elem_t inv2_z;
    logic  singular;
    logic  overflow;
  } mat_out_t;

  // Quotient of one lane, with its sign and a flag for quotients of 2^33 or more.
  typedef struct packed {
    logic [QW-1:0] quo;
    logic          neg;
    logic          big;
  } lane_res_t;

  // Cofactor k = sign * (e[a]*e[b] - e[c]*e[d]); the last column selects negation.
  localparam int unsigned COF_TAB [N_ELEM][5] = '{
    '{4, 8, 7, 5, 0}, '{1, 8, 7, 2, 1}, '{1, 5, 4, 2, 0},
    '{3, 8, 6, 5, 1}, '{0, 8, 6, 2, 0}, '{0, 5, 3, 2, 1},
    '{3, 7, 6, 4, 0}, '{0, 7, 6, 1, 1}, '{0, 4, 3, 1, 0}
  };

endpackage

FILE: rtl/m3i_if.sv
// Valid/ready channel interfaces for the matrix requests and the inverse results.
interface m3i_in_if import m3i_pkg::*; ();
  logic    valid;
  logic    ready;
  mat_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface m3i_out_if import m3i_pkg::*; ();
  logic     valid;
  logic     ready;
  mat_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/m3i_cofactor.sv
// Two-stage cofactor unit: element products, then signed differences.
module m3i_cofactor import m3i_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  elem_t e_i   [N_ELEM],
  output cof_t  cof_o [N_ELEM],
  output elem_t col_o [N_ROW]
);

  prod_t p_q   [N_ELEM][2];
  elem_t col_q [N_ROW];
  cof_t  cof_q [N_ELEM];

  for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
    cof_t diff;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k][0] <= e_i[COF_TAB[k][0]] * e_i[COF_TAB[k][1]];
        p_q[k][1] <= e_i[COF_TAB[k][2]] * e_i[COF_TAB[k][3]];
      end
    end

    assign diff = COF_W'(p_q[k][0]) - COF_W'(p_q[k][1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cof_q[k] <= (COF_TAB[k][4] != 0) ? -diff : diff;
      end
    end

    assign cof_o[k] = cof_q[k];
  end

  // The first column rides along two stages to meet its cofactors.
  for (genvar r = 0; r < N_ROW; r++) begin : g_col
    elem_t col_s1_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        col_s1_q <= e_i[r * N_ROW];
        col_q[r] <= col_s1_q;
      end
    end

    assign col_o[r] = col_q[r];
  end

endmodule

FILE: rtl/m3i_det.sv
// Two-stage determinant: split partial products, then the full-width sum.
module m3i_det import m3i_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  cof_t  cof_i [N_ELEM],
  input  elem_t col_i [N_ROW],
  output cof_t  cof_o [N_ELEM],
  output det_t  det_o,
  output logic  sing_o
);

  logic signed [COF_W-1:0] plo_q [N_ROW];
  logic signed [COF_W-1:0] phi_q [N_ROW];
  cof_t cof_s1_q [N_ELEM];
  cof_t cof_q    [N_ELEM];
  det_t det_q;
  det_t det_d;

  for (genvar r = 0; r < N_ROW; r++) begin : g_part
    logic signed [ELEM_W:0] lo_ext;
    logic signed [ELEM_W:0] hi_ext;

    assign lo_ext = $signed({1'b0, cof_i[r][ELEM_W-1:0]});
    assign hi_ext = $signed(cof_i[r][COF_W-1:ELEM_W]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[r] <= col_i[r] * lo_ext;
        phi_q[r] <= col_i[r] * hi_ext;
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int r = 0; r < N_ROW; r++) begin
      det_d = det_d + DET_W'(plo_q[r]) + (DET_W'(phi_q[r]) <<< ELEM_W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cof_s1_q <= cof_i;
      cof_q    <= cof_s1_q;
      det_q    <= det_d;
    end
  end

  assign cof_o  = cof_q;
  assign det_o  = det_q;
  assign sing_o = (det_q == '0);

endmodule

FILE: rtl/m3i_div_lane.sv
// One division lane: cofactor scaled by 2^(2F) over |det|, one quotient bit per stage.
module m3i_div_lane import m3i_pkg::*; #(
  parameter int unsigned FracBits = M3I_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      en_i,
  input  cof_t      cof_i,
  input  det_t      det_i,
  output lane_res_t res_o
);

  localparam int unsigned NumW  = PROD_W + 2 * FracBits;
  localparam int unsigned TrialW = DMAG_W + QW;
  localparam int unsigned RemW  = ((NumW > TrialW) ? NumW : TrialW) + 1;

  logic [RemW-1:0]   rem_q [QW+1];
  logic [DMAG_W-1:0] den_q [QW+1];
  logic [QW-1:0]     quo_q [QW+1];
  logic              neg_q [QW+1];
  logic              big_q [QW+1];

  cof_t              cmag;
  det_t              dmag;
  logic [RemW-1:0]   num;
  logic              big;

  assign cmag = cof_i[COF_W-1] ? -cof_i : cof_i;
  assign dmag = det_i[DET_W-1] ? -det_i : det_i;
  assign num  = RemW'(cmag[PROD_W-1:0]) << (2 * FracBits);
  assign big  = num >= (RemW'(dmag[DMAG_W-1:0]) << QW);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num;
      den_q[0] <= dmag[DMAG_W-1:0];
      quo_q[0] <= '0;
      neg_q[0] <= cof_i[COF_W-1] ^ det_i[DET_W-1];
      big_q[0] <= big;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int unsigned Bit = QW - k;
    logic [RemW-1:0] trial;
    logic            ge;

    assign trial = RemW'(den_q[k-1]) << Bit;
    assign ge    = rem_q[k-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_q[k-1] - trial : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (QW'(ge) << Bit);
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        big_q[k] <= big_q[k-1];
      end
    end
  end

  assign res_o.quo = quo_q[QW];
  assign res_o.neg = neg_q[QW];
  assign res_o.big = big_q[QW];

endmodule

FILE: rtl/matrix3_inverse_top.sv
// Top level of the pipelined 3x3 matrix inverse in signed Q16.16.
//
// A request on in_i carries one matrix as nine signed fixed-point elements.
// The result on out_o carries the inverse, a singular flag and an overflow flag.
// Both channels are valid/ready; a request moves when valid and ready are high.
// The pipeline accepts one matrix per cycle while it is not stalled; each result
// passes through the products and cofactors, the determinant's partial products
// and sum, a register that sets up the nine division lanes, 33 restoring steps (one
// quotient bit per stage in each lane) and the output register.
// The nine lanes divide the cofactors in parallel; the merge stage saturates
// each quotient, combines the overflow flags and zeroes the matrix when the
// determinant is zero.
// When the receiver stalls, the whole pipeline holds and in_i.ready drops
// until the waiting result is taken.
// Reset clears the valid bits of every stage; data registers are not reset.
module matrix3_inverse_top import m3i_pkg::*; #(
  parameter int unsigned FRAC_BITS = M3I_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  m3i_in_if.sink     in_i,
  m3i_out_if.source  out_o
);

  localparam int unsigned VldLen = 5 + QW;

  logic      en;
  elem_t     elem [N_ELEM];
  cof_t      cof_s2 [N_ELEM];
  elem_t     col_s2 [N_ROW];
  cof_t      cof_s4 [N_ELEM];
  det_t      det_s4;
  logic      sing_s4;
  lane_res_t res [N_ELEM];
  logic      sing_q [QW+1];
  logic      vld_q [VldLen];
  logic      out_vld_q;
  mat_out_t  out_q;
  mat_out_t  out_d;
  elem_t     val [N_ELEM];

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  assign elem[0] = in_i.data.v0_x;
  assign elem[1] = in_i.data.v0_y;
  assign elem[2] = in_i.data.v0_z;
  assign elem[3] = in_i.data.v1_x;
  assign elem[4] = in_i.data.v1_y;
  assign elem[5] = in_i.data.v1_z;
  assign elem[6] = in_i.data.v2_x;
  assign elem[7] = in_i.data.v2_y;
  assign elem[8] = in_i.data.v2_z;

  m3i_cofactor u_cof (
    .clk_i (clk_i),
    .en_i  (en),
    .e_i   (elem),
    .cof_o (cof_s2),
    .col_o (col_s2)
  );

  m3i_det u_det (
    .clk_i  (clk_i),
    .en_i   (en),
    .cof_i  (cof_s2),
    .col_i  (col_s2),
    .cof_o  (cof_s4),
    .det_o  (det_s4),
    .sing_o (sing_s4)
  );

  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    m3i_div_lane #(
      .FracBits (FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .cof_i (cof_s4[k]),
      .det_i (det_s4),
      .res_o (res[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[0] <= sing_s4;
      for (int i = 1; i <= QW; i++) begin
        sing_q[i] <= sing_q[i-1];
      end
    end
  end

  // Saturate each lane's quotient to the 32-bit range, merge the flags and zero a singular result.
  always_comb begin
    logic ovf;
    logic sat;
    ovf = 1'b0;
    for (int k = 0; k < N_ELEM; k++) begin
      if (res[k].neg) begin
        sat    = res[k].big || res[k].quo[QW-1]
                 || (res[k].quo[QW-2] && (res[k].quo[QW-3:0] != '0));
        val[k] = sat ? {1'b1, {(ELEM_W-1){1'b0}}} : -elem_t'(res[k].quo[ELEM_W-1:0]);
      end else begin
        sat    = res[k].big || res[k].quo[QW-1] || res[k].quo[QW-2];
        val[k] = sat ? {1'b0, {(ELEM_W-1){1'b1}}} : elem_t'(res[k].quo[ELEM_W-1:0]);
      end
      ovf = ovf | sat;
      if (sing_q[QW]) begin
        val[k] = '0;
      end
    end
    out_d.inv0_x   = val[0];
    out_d.inv0_y   = val[1];
    out_d.inv0_z   = val[2];
    out_d.inv1_x   = val[3];
    out_d.inv1_y   = val[4];
    out_d.inv1_z   = val[5];
    out_d.inv2_x   = val[6];
    out_d.inv2_y   = val[7];
    out_d.inv2_z   = val[8];
    out_d.singular = sing_q[QW];
    out_d.overflow = ovf && !sing_q[QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VldLen; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int i = 1; i < VldLen; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_vld_q <= vld_q[VldLen-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

FILE: test/m3i_checker.sv
// Checker for the 3x3 matrix inverse: predicts each inverse and compares results.
module m3i_checker import m3i_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_fire_i,
  input  mat_in_t  req_i,
  input  logic     res_fire_i,
  input  mat_out_t res_i,
  output int       errors_o,
  output int       pending_o,
  output int       n_singular_o,
  output int       n_overflow_o
);

  mat_out_t inverse_q[$];

  function automatic mat_out_t predict_inverse(mat_in_t m);
    logic signed [ELEM_W-1:0] e[N_ELEM];
    logic signed [127:0] cof[N_ELEM];
    logic signed [127:0] det;
    logic [127:0] num, den, q;
    logic signed [ELEM_W-1:0] r[N_ELEM];
    logic neg;
    logic ovf;
    mat_out_t o;
    e = '{m.v0_x, m.v0_y, m.v0_z, m.v1_x, m.v1_y, m.v1_z, m.v2_x, m.v2_y, m.v2_z};
    for (int k = 0; k < N_ELEM; k++) begin
      cof[k] = 128'(e[COF_TAB[k][0]]) * 128'(e[COF_TAB[k][1]])
             - 128'(e[COF_TAB[k][2]]) * 128'(e[COF_TAB[k][3]]);
      if (COF_TAB[k][4] != 0) cof[k] = -cof[k];
    end
    det = 128'(e[0]) * cof[0] + 128'(e[3]) * cof[1] + 128'(e[6]) * cof[2];
    ovf = 1'b0;
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    den = det < 0 ? -det : det;
    for (int k = 0; k < N_ELEM; k++) begin
      neg = (cof[k] < 0) != (det < 0);
      num = (cof[k] < 0 ? -cof[k] : cof[k]) << (2 * M3I_FRAC_BITS);
      q = num / den;
      if (neg) begin
        if (q > 128'h8000_0000) begin
          r[k] = 32'h8000_0000;
          ovf = 1'b1;
        end else begin
          r[k] = -q[31:0];
        end
      end else if (q > 128'h7FFF_FFFF) begin
        r[k] = 32'h7FFF_FFFF;
        ovf = 1'b1;
      end else begin
        r[k] = q[31:0];
      end
    end
    o.inv0_x = r[0]; o.inv0_y = r[1]; o.inv0_z = r[2];
    o.inv1_x = r[3]; o.inv1_y = r[4]; o.inv1_z = r[5];
    o.inv2_x = r[6]; o.inv2_y = r[7]; o.inv2_z = r[8];
    o.overflow = ovf;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors_o++;
    $display("m3i_checker: %s mismatch at %0t: got %h, expected %h", what, $time, got, want);
  endtask

  initial begin
    errors_o = 0;
    n_singular_o = 0;
    n_overflow_o = 0;
  end

  assign pending_o = inverse_q.size();

  always @(posedge clk_i) begin
    mat_out_t want;
    if (rst_ni) begin
      if (req_fire_i) begin
        want = predict_inverse(req_i);
        inverse_q.push_back(want);
        if (want.singular) n_singular_o++;
        if (want.overflow) n_overflow_o++;
      end
      if (res_fire_i) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(res_i.inv0_x), 64'd0);
        end else begin
          want = inverse_q.pop_front();
          if (res_i.inv0_x !== want.inv0_x) report_mismatch("inv0_x", res_i.inv0_x, want.inv0_x);
          if (res_i.inv0_y !== want.inv0_y) report_mismatch("inv0_y", res_i.inv0_y, want.inv0_y);
          if (res_i.inv0_z !== want.inv0_z) report_mismatch("inv0_z", res_i.inv0_z, want.inv0_z);
          if (res_i.inv1_x !== want.inv1_x) report_mismatch("inv1_x", res_i.inv1_x, want.inv1_x);
          if (res_i.inv1_y !== want.inv1_y) report_mismatch("inv1_y", res_i.inv1_y, want.inv1_y);
          if (res_i.inv1_z !== want.inv1_z) report_mismatch("inv1_z", res_i.inv1_z, want.inv1_z);
          if (res_i.inv2_x !== want.inv2_x) report_mismatch("inv2_x", res_i.inv2_x, want.inv2_x);
          if (res_i.inv2_y !== want.inv2_y) report_mismatch("inv2_y", res_i.inv2_y, want.inv2_y);
          if (res_i.inv2_z !== want.inv2_z) report_mismatch("inv2_z", res_i.inv2_z, want.inv2_z);
          if (res_i.singular !== want.singular)
            report_mismatch("singular", res_i.singular, want.singular);
          if (res_i.overflow !== want.overflow)
            report_mismatch("overflow", res_i.overflow, want.overflow);
        end
      end
    end
  end

endmodule

FILE: test/tb_top.sv
// Testbench top: drives matrix requests into the inverse and gives the verdict.
module tb_top import m3i_pkg::*;;

  localparam int LATENCY    = 39;
  localparam int N_RANDOM   = 500;
  localparam int CYCLE_CAP  = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  m3i_in_if  in_ch();
  m3i_out_if out_ch();

  int errors, pending, n_singular, n_overflow;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int n_sent = 0;
  int n_results = 0;

  always #1 clk_i = ~clk_i;

  matrix3_inverse_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  m3i_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_fire_i   (in_ch.valid && in_ch.ready),
    .req_i        (in_ch.data),
    .res_fire_i   (out_ch.valid && out_ch.ready),
    .res_i        (out_ch.data),
    .errors_o     (errors),
    .pending_o    (pending),
    .n_singular_o (n_singular),
    .n_overflow_o (n_overflow)
  );

  // Receiver: random stalls, plus a long hold-off counted here.
  initial out_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) n_results++;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
      2: return elem_t'($urandom_range(255)) - 32'sd128;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0001_0000;
          default: return 32'sh0;
        endcase
      end
    endcase
  endfunction

  function automatic mat_in_t rand_matrix();
    mat_in_t m;
    int mode;
    mode = $urandom_range(9);
    mode = mode < 2 ? 0 : (mode < 7 ? 1 : (mode < 8 ? 2 : 3));
    m.v0_x = rand_elem(mode); m.v0_y = rand_elem(mode); m.v0_z = rand_elem(mode);
    m.v1_x = rand_elem(mode); m.v1_y = rand_elem(mode); m.v1_z = rand_elem(mode);
    m.v2_x = rand_elem(mode); m.v2_y = rand_elem(mode); m.v2_z = rand_elem(mode);
    // Sometimes copy a vector so the determinant is zero.
    if ($urandom_range(9) == 0) begin
      m.v2_x = m.v0_x; m.v2_y = m.v0_y; m.v2_z = m.v0_z;
    end
    return m;
  endfunction

  function automatic mat_in_t diag(elem_t a, elem_t b, elem_t c);
    mat_in_t m;
    m = '0;
    m.v0_x = a; m.v1_y = b; m.v2_z = c;
    return m;
  endfunction

  // Offers one matrix, with random idle cycles before it, and waits for acceptance.
  task automatic send_matrix(mat_in_t m);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    mat_in_t m;
    int drain_wait;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, scaled diagonals, extremes, singular and overflow cases.
    send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
    send_matrix(diag(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001));
    send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag(32'sh8000_0000, 32'sh0001_0000, -32'sh0001_0000));
    send_matrix(diag(-32'sh0001_0000, 32'sh0000_0001, 32'sh7FFF_FFFF));
    send_matrix('0);
    send_matrix('1);
    m = '1;
    m.v0_x = 32'sh7FFF_FFFF; m.v1_y = 32'sh8000_0000; m.v2_z = 32'sh0001_0000;
    send_matrix(m);
    m = diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000);
    send_matrix(m);
    m = '{v0_x: 32'sh0001_0000, v0_y: 32'sh0002_0000, v0_z: 32'sh0003_0000,
          v1_x: 32'sh0000_0000, v1_y: 32'sh0001_0000, v1_z: 32'sh0004_0000,
          v2_x: 32'sh0005_0000, v2_y: 32'sh0006_0000, v2_z: 32'sh0000_0000};
    send_matrix(m);
    m.v2_x = 32'sh0001_0000; m.v2_y = 32'sh0002_0000; m.v2_z = 32'sh0003_0000;
    send_matrix(m);
    m = '{v0_x: 32'sh5555_5555, v0_y: 32'shAAAA_AAAA, v0_z: 32'sh0F0F_0F0F,
          v1_x: 32'shF0F0_F0F0, v1_y: 32'sh3333_3333, v1_z: 32'shCCCC_CCCC,
          v2_x: 32'sh0000_FFFF, v2_y: 32'shFFFF_0000, v2_z: 32'sh1234_5678};
    send_matrix(m);
    drain();

    // Sender pauses until every result is back, then the receiver holds off long.
    hold_cycles = 150;
    for (int i = 0; i < 60; i++) send_matrix(rand_matrix());

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 71 : 11) : 0;
      stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 71 : 11) : 0;
      for (int i = 0; i < N_RANDOM / 4; i++) send_matrix(rand_matrix());
    end
    in_ch.valid <= 1'b0;

    drain_wait = 0;
    while (pending != 0 && drain_wait < 20 * CYCLE_CAP) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("tb_top: %0d matrices sent, %0d inverses checked (%0d singular, %0d saturating).",
             n_sent, n_results, n_singular, n_overflow);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
